[rtl/core/eida_pkg.sv]
// eida_pkg: shared types and constants for the entity id allocator.
// Field widths, operation and status codes, controller/datapath structs.
// No dependencies.
package eida_pkg;

  localparam int DEF_MAX_ENTITIES   = 1024;
  localparam int DEF_SIGNATURE_BITS = 32;

  localparam int OP_W        = 2;
  localparam int ID_FIELD_W  = 11;
  localparam int SIG_FIELD_W = 32;
  localparam int STATUS_W    = 2;

  typedef enum logic [OP_W-1:0] {
    OP_REGISTER = 2'd0,
    OP_REMOVE   = 2'd1,
    OP_SET_SIG  = 2'd2,
    OP_GET_SIG  = 2'd3
  } op_t;

  localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOT_LIVE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic capture;     // latch operands, launch memory reads
    logic exec;        // evaluate, write back, load result
    logic clear_step;  // clear one live mark
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clear_last;  // clear pointer at last entry
  } dp_stat_t;

endpackage

[rtl/core/eida_ctrl.sv]
// eida_ctrl: sequencer for the entity id allocator.
// Depends on eida_pkg (dp_cmd_t, dp_stat_t).
module eida_ctrl
  import eida_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy,
  output logic     done
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

endmodule

[rtl/core/eida_dp.sv]
// eida_dp: datapath of the entity id allocator: counters, free stack,
// live marks and signature store, result registers. Depends on eida_pkg.
module eida_dp
  import eida_pkg::*;
#(
  parameter int MAX_ENTITIES   = DEF_MAX_ENTITIES,
  parameter int SIGNATURE_BITS = DEF_SIGNATURE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dp_cmd_t                cmd,
  output dp_stat_t               stat,
  input  logic [OP_W-1:0]        op,
  input  logic [ID_FIELD_W-1:0]  entity_id,
  input  logic [SIG_FIELD_W-1:0] signature_in,
  output logic [ID_FIELD_W-1:0]  entity_id_out,
  output logic [SIG_FIELD_W-1:0] signature_out,
  output logic [STATUS_W-1:0]    status
);

  localparam int IDX_W = $clog2(MAX_ENTITIES);
  localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
  localparam int IDC_W = (CNT_W > ID_FIELD_W) ? CNT_W : ID_FIELD_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTITIES);
  localparam logic [IDC_W-1:0] MAX_IDC = IDC_W'(MAX_ENTITIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTITIES - 1);

  // memories
  logic                      live_mem [MAX_ENTITIES];
  logic [CNT_W-1:0]          stack_mem[MAX_ENTITIES];
  logic [SIGNATURE_BITS-1:0] sig_mem  [MAX_ENTITIES];

  // state
  logic [CNT_W-1:0] fresh_counter, fresh_counter_next;
  logic [CNT_W-1:0] free_count, free_count_next;
  logic [IDX_W-1:0] clr_addr;

  // captured operands and read data
  op_t                       op_q;
  logic [ID_FIELD_W-1:0]     id_q;
  logic [SIGNATURE_BITS-1:0] sig_q;
  logic                      id_ok_q;
  logic                      live_rd;
  logic [CNT_W-1:0]          stack_rd;
  logic [SIGNATURE_BITS-1:0] sig_rd;

  // incoming identifier check and index
  logic [IDC_W-1:0] id_ext;
  logic             id_ok;
  logic [IDX_W-1:0] id_idx;

  assign id_ext = IDC_W'(entity_id);
  assign id_ok  = (id_ext != '0) && (id_ext <= MAX_IDC);
  assign id_idx = IDX_W'(id_ext - IDC_W'(1));

  assign stat.clear_last = (clr_addr == LAST_IDX);

  // evaluation
  logic [IDX_W-1:0]          q_idx;
  logic [CNT_W-1:0]          granted;
  logic                      grant_ok;
  logic                      live_we, live_wd;
  logic [IDX_W-1:0]          live_wa;
  logic                      stack_we;
  logic                      sig_we;
  logic [IDX_W-1:0]          sig_wa;
  logic [SIGNATURE_BITS-1:0] sig_wd;
  logic [ID_FIELD_W-1:0]     id_res;
  logic [SIG_FIELD_W-1:0]    sig_res;
  logic [STATUS_W-1:0]       stat_res;

  assign q_idx = IDX_W'(IDC_W'(id_q) - IDC_W'(1));

  always_comb begin
    fresh_counter_next = fresh_counter;
    free_count_next    = free_count;
    granted            = '0;
    grant_ok           = 1'b0;
    live_we            = 1'b0;
    live_wd            = 1'b0;
    live_wa            = q_idx;
    stack_we           = 1'b0;
    sig_we             = 1'b0;
    sig_wa             = q_idx;
    sig_wd             = sig_q;
    id_res             = id_q;
    sig_res            = '0;
    stat_res           = STAT_OK;
    if (op_q == OP_REGISTER) begin
      if (free_count != '0) begin
        free_count_next = free_count - CNT_W'(1);
        granted         = stack_rd;
        grant_ok        = 1'b1;
      end else if (fresh_counter < MAX_CNT) begin
        fresh_counter_next = fresh_counter + CNT_W'(1);
        granted            = fresh_counter + CNT_W'(1);
        grant_ok           = 1'b1;
      end
      if (grant_ok) begin
        live_we = 1'b1;
        live_wd = 1'b1;
        live_wa = IDX_W'(granted - CNT_W'(1));
        sig_we  = 1'b1;
        sig_wa  = IDX_W'(granted - CNT_W'(1));
        sig_wd  = '0;
        id_res  = ID_FIELD_W'(granted);
      end else begin
        id_res   = '0;
        stat_res = STAT_FULL;
      end
    end else if (!(id_ok_q && live_rd)) begin
      stat_res = STAT_NOT_LIVE;
    end else begin
      case (op_q)
        OP_REMOVE: begin
          live_we = 1'b1;
          if (free_count < MAX_CNT) begin
            stack_we        = 1'b1;
            free_count_next = free_count + CNT_W'(1);
          end
        end
        OP_SET_SIG: sig_we = 1'b1;
        OP_GET_SIG: sig_res = SIG_FIELD_W'(sig_rd);
        default: ;
      endcase
    end
  end

  // counters and clear pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      fresh_counter <= '0;
      free_count    <= '0;
      clr_addr      <= '0;
    end else begin
      if (cmd.exec) begin
        fresh_counter <= fresh_counter_next;
        free_count    <= free_count_next;
      end
      if (cmd.clear_step) clr_addr <= clr_addr + IDX_W'(1);
    end
  end

  // operand capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op_t'(op);
      id_q    <= entity_id;
      sig_q   <= SIGNATURE_BITS'(signature_in);
      id_ok_q <= id_ok;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      entity_id_out <= id_res;
      signature_out <= sig_res;
      status        <= stat_res;
    end
  end

  // live marks: clear pass or single write, registered read
  always_ff @(posedge clk) begin
    if (cmd.clear_step) live_mem[clr_addr] <= 1'b0;
    else if (cmd.exec && live_we) live_mem[live_wa] <= live_wd;
    if (cmd.capture) live_rd <= live_mem[id_idx];
  end

  // free stack: top-of-stack read at capture
  always_ff @(posedge clk) begin
    if (cmd.exec && stack_we) stack_mem[IDX_W'(free_count)] <= CNT_W'(IDC_W'(id_q));
    if (cmd.capture) stack_rd <= stack_mem[IDX_W'(free_count - CNT_W'(1))];
  end

  // signature store
  always_ff @(posedge clk) begin
    if (cmd.exec && sig_we) sig_mem[sig_wa] <= sig_wd;
    if (cmd.capture) sig_rd <= sig_mem[id_idx];
  end

endmodule

[rtl/core/entity_id_allocator_with_signatures.sv]
// entity_id_allocator_with_signatures: top level of the entity id allocator.
// Depends on eida_pkg, eida_ctrl and eida_dp.
//
// Command-style allocator. An operation is transferred at a rising edge with
// start high and busy low. The transfer edge launches the registered
// reads of the live marks, free stack and signature store, and the
// following execute cycle evaluates and writes back. The
// result (entity_id_out, signature_out, status) is shown for exactly one
// cycle with done high, in the cycle after execute; it must be taken then,
// since the receiver cannot stall the block. busy is low during that result
// cycle, so the next operation can be transferred while the result is shown.
// After reset the block runs a clearing pass over all MAX_ENTITIES live
// marks, one entry per cycle, with busy high. Op codes: 0 register, 1 remove,
// 2 set signature, 3 get signature. Status: 0 ok, 1 entity not live, 2 no
// identifiers left. Register pops the most recently freed id, else issues
// the next fresh id starting at 1, and clears its signature.
module entity_id_allocator_with_signatures
  import eida_pkg::*;
#(
  parameter int MAX_ENTITIES   = DEF_MAX_ENTITIES,
  parameter int SIGNATURE_BITS = DEF_SIGNATURE_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [OP_W-1:0]        op,
  input  logic [ID_FIELD_W-1:0]  entity_id,
  input  logic [SIG_FIELD_W-1:0] signature_in,
  output logic                   done,
  output logic [ID_FIELD_W-1:0]  entity_id_out,
  output logic [SIG_FIELD_W-1:0] signature_out,
  output logic [STATUS_W-1:0]    status
);

  dp_cmd_t  cmd;   // sequencer commands
  dp_stat_t stat;  // datapath status

  eida_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  eida_dp #(
    .MAX_ENTITIES   (MAX_ENTITIES),
    .SIGNATURE_BITS (SIGNATURE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (op),
    .entity_id     (entity_id),
    .signature_in  (signature_in),
    .entity_id_out (entity_id_out),
    .signature_out (signature_out),
    .status        (status)
  );

endmodule

[tb/entity_id_allocator_with_signatures_tb.sv]
// entity_id_allocator_with_signatures_tb: self-checking testbench for the entity id allocator.
// Drives directed and random register/remove/set/get operations and checks every result.
// Depends on eida_pkg and entity_id_allocator_with_signatures.
`timescale 1ns / 100ps

module entity_id_allocator_with_signatures_tb;
  import eida_pkg::*;

  localparam int MAX_ENTITIES = DEF_MAX_ENTITIES;
  localparam int RANDOM_ITEMS = 2000;
  // Nothing moves during the clearing pass after reset, nor in the longest
  // sender gap; the limit covers both several times over.
  localparam int STALL_LIMIT  = 4 * MAX_ENTITIES + 400;

  typedef struct {
    op_t                   op;
    logic [ID_FIELD_W-1:0]  id;
    logic [SIG_FIELD_W-1:0] sig;
  } alloc_cmd_t;

  typedef struct {
    logic [ID_FIELD_W-1:0]  id;
    logic [SIG_FIELD_W-1:0] sig;
    logic [STATUS_W-1:0]    status;
  } alloc_resp_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic [OP_W-1:0]        op = OP_REGISTER;
  logic [ID_FIELD_W-1:0]  entity_id = '0;
  logic [SIG_FIELD_W-1:0] signature_in = '0;
  logic                   busy;
  logic                   done;
  logic [ID_FIELD_W-1:0]  entity_id_out;
  logic [SIG_FIELD_W-1:0] signature_out;
  logic [STATUS_W-1:0]    status;

  entity_id_allocator_with_signatures #(
    .MAX_ENTITIES   (MAX_ENTITIES),
    .SIGNATURE_BITS (DEF_SIGNATURE_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .op            (op),
    .entity_id     (entity_id),
    .signature_in  (signature_in),
    .done          (done),
    .entity_id_out (entity_id_out),
    .signature_out (signature_out),
    .status        (status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Operations waiting to be driven, and results owed by the block, oldest first.
  alloc_cmd_t  pending_ops[$];
  alloc_resp_t expected_results[$];
  int          error_count = 0;

  // ---------------------------------------------------------------------------
  // Shadow allocator. Updated at each accepted transfer, so it always holds the
  // state the block should have after the last accepted operation.
  // ---------------------------------------------------------------------------
  bit                     id_live[1:MAX_ENTITIES];
  logic [SIG_FIELD_W-1:0] sig_shadow[1:MAX_ENTITIES];
  logic [ID_FIELD_W-1:0]  recycled_ids[0:MAX_ENTITIES-1];
  int                     recycled_cnt = 0;
  int                     fresh_hi = 0;   // highest fresh id handed out so far

  task automatic apply_alloc_op(input op_t code, input logic [ID_FIELD_W-1:0] id,
                                input logic [SIG_FIELD_W-1:0] sig);
    alloc_resp_t r;
    int          granted;
    r.id     = id;
    r.sig    = '0;
    r.status = STAT_OK;
    if (code == OP_REGISTER) begin
      granted = 0;
      // LIFO reuse first, then fresh numbers from 1 up
      if (recycled_cnt > 0) begin
        recycled_cnt--;
        granted = recycled_ids[recycled_cnt];
      end else if (fresh_hi < MAX_ENTITIES) begin
        fresh_hi++;
        granted = fresh_hi;
      end
      if (granted == 0) begin
        r.status = STAT_FULL;
        r.id     = '0;
      end else begin
        id_live[granted]    = 1'b1;
        sig_shadow[granted] = '0;
        r.id                = granted[ID_FIELD_W-1:0];
      end
    end else if (id == 0 || id > MAX_ENTITIES || !id_live[id]) begin
      // zero, out of range, or not live: error, nothing changes
      r.status = STAT_NOT_LIVE;
    end else begin
      case (code)
        OP_REMOVE: begin
          id_live[id] = 1'b0;
          if (recycled_cnt < MAX_ENTITIES) begin
            recycled_ids[recycled_cnt] = id;
            recycled_cnt++;
          end
        end
        OP_SET_SIG: sig_shadow[id] = sig;
        default:    r.sig = sig_shadow[id];
      endcase
    end
    expected_results.insert(expected_results.size(), r);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents the next pending operation and holds it until the
  // transfer edge (start high, busy low). Random gaps follow each transfer.
  // ---------------------------------------------------------------------------
  int idle_left = 0;
  int idle_style = 0;   // 0 none, 1 short gaps, 2 mostly short with a few long

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    case (idle_style)
      0: return 0;
      1: return $urandom_range(0, 3);
      default: begin
        if (roll < 70) return $urandom_range(0, 2);
        else if (roll < 95) return $urandom_range(3, 8);
        else return $urandom_range(20, 60);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    bit         next_start;
    alloc_cmd_t cmd;
    if (rst) begin
      start     <= 1'b0;
      idle_left = 0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        apply_alloc_op(op_t'(op), entity_id, signature_in);
        next_start = 1'b0;
        if ($urandom_range(0, 149) == 0) idle_style = $urandom_range(0, 2);
        idle_left = pick_gap();
      end
      if (!next_start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_ops.size() != 0) begin
          cmd = pending_ops.pop_front();
          op           <= cmd.op;
          entity_id    <= cmd.id;
          signature_in <= cmd.sig;
          next_start   = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every done strobe is one result transfer, checked against the
  // oldest expectation field by field.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    alloc_resp_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: entity_id_out %0d signature_out %h status %0d",
               entity_id_out, signature_out, status);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (entity_id_out !== want.id) begin
          $error("entity_id_out: expected %0d, actual %0d", want.id, entity_id_out);
          error_count++;
        end
        if (signature_out !== want.sig) begin
          $error("signature_out: expected %h, actual %h", want.sig, signature_out);
          error_count++;
        end
        if (status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: cycles in a row with neither an input nor a result transfer.
  int stall_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** entity_id_allocator_with_signatures: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int random_sent = 0;

  task automatic push_cmd(input op_t code, input int id, input logic [SIG_FIELD_W-1:0] sig);
    alloc_cmd_t c;
    c.op  = code;
    c.id  = id[ID_FIELD_W-1:0];
    c.sig = sig;
    pending_ops.insert(pending_ops.size(), c);
  endtask

  // Picks an id that is live in the shadow state. The shadow lags the queue by
  // the operation in flight, so now and then this hits a just-removed id.
  function automatic int pick_live_id();
    int cand;
    if (fresh_hi == 0) return 1;
    for (int i = 0; i < 16; i++) begin
      cand = $urandom_range(1, fresh_hi);
      if (id_live[cand]) return cand;
    end
    return cand;
  endfunction

  // Error cases: id zero, ids beyond the table (bit 10 set), any id in the
  // table (often one never granted), or one granted earlier that may since
  // have been removed.
  function automatic int pick_noise_id();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return $urandom_range(MAX_ENTITIES + 1, (1 << ID_FIELD_W) - 1);
      2: return $urandom_range(1, MAX_ENTITIES);
      default: return (fresh_hi == 0) ? 0 : $urandom_range(1, fresh_hi);
    endcase
  endfunction

  function automatic logic [SIG_FIELD_W-1:0] pick_sig();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return $urandom;
  endfunction

  // One random operation; waits until the previous one has been taken so the
  // id choice sees nearly current state.
  task automatic queue_random_op(input int w_reg, input int w_rem, input int noise_pct);
    int  roll;
    int  id;
    op_t code;
    while (pending_ops.size() != 0) @(negedge clk);
    roll = $urandom_range(0, 99);
    if (roll < w_reg) code = OP_REGISTER;
    else if (roll < w_reg + w_rem) code = OP_REMOVE;
    else code = $urandom_range(0, 1) ? OP_SET_SIG : OP_GET_SIG;
    if (code == OP_REGISTER) id = $urandom_range(0, (1 << ID_FIELD_W) - 1);
    else if ($urandom_range(0, 99) < noise_pct) id = pick_noise_id();
    else id = pick_live_id();
    push_cmd(code, id, pick_sig());
    random_sent++;
  endtask

  initial begin
    // Directed: basic grants, signature extremes, error ids, LIFO reuse.
    push_cmd(OP_REGISTER, 0, '0);              // grants 1
    push_cmd(OP_REGISTER, 2047, '1);           // grants 2, id field ignored
    push_cmd(OP_GET_SIG, 1, '0);               // fresh entry reads zero
    push_cmd(OP_SET_SIG, 1, 32'hFFFF_FFFF);
    push_cmd(OP_GET_SIG, 1, '0);
    push_cmd(OP_SET_SIG, 2, 32'h8000_0001);
    push_cmd(OP_GET_SIG, 2, 32'h1234_5678);
    push_cmd(OP_SET_SIG, 0, 32'hDEAD_BEEF);    // id zero: not live
    push_cmd(OP_GET_SIG, 0, '0);
    push_cmd(OP_REMOVE, 0, '0);
    push_cmd(OP_REMOVE, MAX_ENTITIES + 1, '0); // just past the table
    push_cmd(OP_GET_SIG, 2047, '1);            // all id bits set
    push_cmd(OP_SET_SIG, 2047, '1);
    push_cmd(OP_REMOVE, 1, '0);
    push_cmd(OP_REMOVE, 1, '0);                // already removed
    push_cmd(OP_GET_SIG, 1, '0);               // removed: not live, reads zero
    push_cmd(OP_SET_SIG, 1, 32'h5555_5555);
    push_cmd(OP_REGISTER, 0, '0);              // reuses 1, signature cleared
    push_cmd(OP_GET_SIG, 1, '0);
    push_cmd(OP_REMOVE, 2, '0);
    push_cmd(OP_REMOVE, 1, '0);
    push_cmd(OP_REGISTER, 0, '0);              // LIFO: 1 first
    push_cmd(OP_REGISTER, 0, '0);              // then 2
    push_cmd(OP_REGISTER, 0, '0);              // stack empty: fresh 3

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Mixed traffic on a partly filled table.
    while (random_sent < 200) queue_random_op(30, 15, 10);
    // Fill the table until fresh ids and the free stack are both used up.
    while (fresh_hi < MAX_ENTITIES || recycled_cnt != 0) queue_random_op(85, 5, 5);
    for (int i = 0; i < 8; i++) queue_random_op(100, 0, 0);   // table full
    // Heavy churn: many removes, then reuse from the stack.
    for (int i = 0; i < 300; i++) queue_random_op(15, 55, 10);
    for (int i = 0; i < 150; i++) queue_random_op(60, 10, 10);
    while (random_sent < RANDOM_ITEMS) queue_random_op(35, 20, 15);

    // Drain: everything taken, every result seen, then a few quiet cycles.
    while (pending_ops.size() != 0 || start || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("** entity_id_allocator_with_signatures: PASSED **");
    end else begin
      $display("** entity_id_allocator_with_signatures: FAILED **");
    end
    $finish;
  end

endmodule
